// ----- hdl/fbsm_pkg.sv -----
// Shared types and constants for the framed bus slave mailbox.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fbsm_pkg;

  // Mailbox address width for the largest supported depth (64 entries).
  localparam int unsigned MEM_AW = 6;
  // Reply beat counter: two header beats plus up to 31 mailbox bytes.
  localparam int unsigned REPLY_CW = 6;

  typedef enum logic [2:0] {
    CMD_BUS   = 3'd0,
    CMD_WBYTE = 3'd1,
    CMD_WBIT  = 3'd2,
    CMD_RBYTE = 3'd3,
    CMD_FLAG  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_UNIT_ID   = 3'd0,
    REG_IN_SIZE   = 3'd1,
    REG_OUT_SIZE  = 3'd2,
    REG_START_ONE = 3'd3,
    REG_START_TWO = 3'd4,
    REG_REPLY_ONE = 3'd5,
    REG_REPLY_TWO = 3'd6,
    REG_WRITE_OP  = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    FR_ONE  = 2'd0,
    FR_TWO  = 2'd1,
    FR_ADDR = 2'd2,
    FR_PAY  = 2'd3
  } frame_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RREAD,
    S_RSEND,
    S_CREAD,
    S_CPUT,
    S_RMW,
    S_HREAD,
    S_FLAG
  } seq_state_e;

  typedef struct packed {
    logic [6:0] unit_id;
    logic [4:0] in_size;
    logic [4:0] out_size;
    logic [7:0] start_one;
    logic [7:0] start_two;
    logic [7:0] reply_one;
    logic [7:0] reply_two;
    logic       write_op;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- hdl/framed_bus_slave_mailbox.sv -----
// Top level: configuration registers, sequencer and the two mailbox memories.
// Bus byte, host byte write, unknown command: no result, except a bus byte that starts a read reply.
// Host read / flag take: registered result; bit write: read then write, skipped if ignored.
// Read reply: each beat is a mailbox read then a send (one shared mailbox read port).
// Write commit copies the staging buffer byte by byte. Output stalls keep the block busy.
// Reset clears config, frame state, changes flag and mailbox valid bits at once.
`timescale 1ns / 1ps
`default_nettype none

module framed_bus_slave_mailbox #(
  parameter int unsigned IN_MAX  = 16,
  parameter int unsigned OUT_MAX = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] command_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [7:0] byte_index_i,
  input  wire logic [2:0] bit_index_i,
  input  wire logic       bit_value_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            kind_o,
  output logic [7:0]      value_o,
  output logic            last_o
);
  import fbsm_pkg::*;

  cfg_t     cfg_q;
  mem_req_t ibox_req;
  mem_req_t obox_req;
  logic [7:0] ibox_rdata;
  logic [7:0] obox_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_UNIT_ID:   cfg_q.unit_id   <= cfg_data_i[6:0];
        REG_IN_SIZE:   cfg_q.in_size   <= cfg_data_i[4:0];
        REG_OUT_SIZE:  cfg_q.out_size  <= cfg_data_i[4:0];
        REG_START_ONE: cfg_q.start_one <= cfg_data_i;
        REG_START_TWO: cfg_q.start_two <= cfg_data_i;
        REG_REPLY_ONE: cfg_q.reply_one <= cfg_data_i;
        REG_REPLY_TWO: cfg_q.reply_two <= cfg_data_i;
        REG_WRITE_OP:  cfg_q.write_op  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  fbsm_seq #(
    .IN_MAX  (IN_MAX),
    .OUT_MAX (OUT_MAX)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .byte_index_i (byte_index_i),
    .bit_index_i  (bit_index_i),
    .bit_value_i  (bit_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .last_o       (last_o),
    .ibox_req_o   (ibox_req),
    .ibox_rdata_i (ibox_rdata),
    .obox_req_o   (obox_req),
    .obox_rdata_i (obox_rdata)
  );

  fbsm_vram #(
    .DEPTH (IN_MAX)
  ) u_ibox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ibox_req),
    .rdata_o (ibox_rdata)
  );

  fbsm_vram #(
    .DEPTH (OUT_MAX)
  ) u_obox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (obox_req),
    .rdata_o (obox_rdata)
  );

endmodule

`default_nettype wire

// ----- hdl/fbsm_vram.sv -----
// Byte mailbox memory: one write port, one registered read port.
// Per-entry valid bits cleared by reset; unwritten entries read as zero. Uses fbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbsm_vram #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fbsm_pkg::mem_req_t req_i,
  output logic [7:0]              rdata_o
);
  import fbsm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       rdata_q;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;

  assign waddr   = req_i.waddr[AW-1:0];
  assign raddr   = req_i.raddr[AW-1:0];
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= valid_q[raddr] ? mem_q[raddr] : 8'd0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fbsm_seq.sv -----
// Sequencer: frame state machine, staging buffer, commit copy, reply streaming
// and host commands, driving the two mailbox memories. Uses fbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbsm_seq #(
  parameter int unsigned IN_MAX  = 16,
  parameter int unsigned OUT_MAX = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fbsm_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         command_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic [7:0]         byte_index_i,
  input  wire logic [2:0]         bit_index_i,
  input  wire logic               bit_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    kind_o,
  output logic [7:0]              value_o,
  output logic                    last_o,
  output fbsm_pkg::mem_req_t      ibox_req_o,
  input  wire logic [7:0]         ibox_rdata_i,
  output fbsm_pkg::mem_req_t      obox_req_o,
  input  wire logic [7:0]         obox_rdata_i
);
  import fbsm_pkg::*;

  localparam int unsigned IAW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;

  seq_state_e state_q, state_d;
  frame_e     frame_q, frame_d;
  logic [4:0] pcnt_q, pcnt_d;
  logic [4:0] ccnt_q, ccnt_d;
  logic [REPLY_CW-1:0] rcnt_q, rcnt_d;
  logic       flag_q, flag_d;
  logic       hit_q, hit_d;

  cmd_e       cmd_q;
  logic [7:0] data_q;
  logic [7:0] idx_q;
  logic [2:0] bit_q;
  logic       bval_q;

  logic       out_valid_q;
  logic       out_kind_q;
  logic [7:0] out_value_q;
  logic       out_last_q;

  logic [7:0] stg_mem_q [IN_MAX];
  logic [7:0] stg_rdata_q;
  logic       stg_we;
  logic       stg_re;

  logic       in_acc;
  logic       free;
  logic [4:0] eff_in;
  logic [4:0] eff_out;
  logic       idx_in_in;
  logic       idx_in_out;
  logic [4:0] pcnt_nx;
  logic       pay_store;
  logic       pay_done;
  logic [REPLY_CW-1:0] reply_end;
  logic       reply_last;
  logic       copy_last;
  logic [7:0] bit_mask;
  logic [7:0] rmw_value;
  logic [7:0] reply_value;

  logic       emit;
  logic       emit_kind;
  logic [7:0] emit_value;
  logic       emit_last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign free        = !out_valid_q || out_ready_i;

  assign eff_in  = (int'(cfg_i.in_size) > IN_MAX) ? 5'(IN_MAX) : cfg_i.in_size;
  assign eff_out = (int'(cfg_i.out_size) > OUT_MAX) ? 5'(OUT_MAX) : cfg_i.out_size;

  assign idx_in_in  = idx_q < {3'b000, eff_in};
  assign idx_in_out = idx_q < {3'b000, eff_out};

  assign pay_store = pcnt_q < eff_in;
  assign pcnt_nx   = pay_store ? pcnt_q + 5'd1 : pcnt_q;
  assign pay_done  = pcnt_nx >= eff_in;

  assign reply_end  = {1'b0, eff_out} + REPLY_CW'(1);
  assign reply_last = rcnt_q == reply_end;
  assign copy_last  = ccnt_q == (eff_in - 5'd1);

  assign bit_mask  = 8'd1 << bit_q;
  assign rmw_value = bval_q ? (obox_rdata_i | bit_mask) : (obox_rdata_i & ~bit_mask);

  always_comb begin
    if (rcnt_q == REPLY_CW'(0)) begin
      reply_value = cfg_i.reply_one;
    end else if (rcnt_q == REPLY_CW'(1)) begin
      reply_value = cfg_i.reply_two;
    end else begin
      reply_value = obox_rdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (cmd_q)
          CMD_BUS: begin
            if (frame_q == FR_ADDR && data_q[7:1] == cfg_i.unit_id &&
                data_q[0] != cfg_i.write_op) begin
              state_d = S_RREAD;
            end else if (frame_q == FR_PAY && pay_done && eff_in != 5'd0) begin
              state_d = S_CREAD;
            end
          end
          CMD_WBIT:  state_d = idx_in_out ? S_RMW : S_IDLE;
          CMD_RBYTE: state_d = S_HREAD;
          CMD_FLAG:  state_d = S_FLAG;
          default:   state_d = S_IDLE;
        endcase
      end
      S_RREAD: state_d = S_RSEND;
      S_RSEND: begin
        if (free) begin
          state_d = reply_last ? S_IDLE : S_RREAD;
        end
      end
      S_CREAD: state_d = S_CPUT;
      S_CPUT:  state_d = copy_last ? S_IDLE : S_CREAD;
      S_RMW:   state_d = S_IDLE;
      S_HREAD: state_d = free ? S_IDLE : S_HREAD;
      S_FLAG:  state_d = free ? S_IDLE : S_FLAG;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    frame_d    = frame_q;
    pcnt_d     = pcnt_q;
    ccnt_d     = ccnt_q;
    rcnt_d     = rcnt_q;
    flag_d     = flag_q;
    hit_d      = hit_q;
    stg_we     = 1'b0;
    stg_re     = 1'b0;
    ibox_req_o = '0;
    obox_req_o = '0;
    emit       = 1'b0;
    emit_kind  = 1'b0;
    emit_value = 8'd0;
    emit_last  = 1'b0;
    unique case (state_q)
      S_EXEC: begin
        case (cmd_q)
          CMD_BUS: begin
            unique case (frame_q)
              FR_ONE: begin
                if (data_q == cfg_i.start_one) begin
                  frame_d = FR_TWO;
                end
              end
              FR_TWO:  frame_d = (data_q == cfg_i.start_two) ? FR_ADDR : FR_ONE;
              FR_ADDR: begin
                frame_d = FR_ONE;
                if (data_q[7:1] == cfg_i.unit_id) begin
                  if (data_q[0] == cfg_i.write_op) begin
                    frame_d = FR_PAY;
                    pcnt_d  = 5'd0;
                  end else begin
                    rcnt_d = '0;
                  end
                end
              end
              FR_PAY: begin
                stg_we = pay_store;
                pcnt_d = pcnt_nx;
                if (pay_done) begin
                  frame_d = FR_ONE;
                  flag_d  = 1'b1;
                  ccnt_d  = 5'd0;
                end
              end
              default: frame_d = FR_ONE;
            endcase
          end
          CMD_WBYTE: begin
            obox_req_o.we    = idx_in_out;
            obox_req_o.waddr = MEM_AW'(idx_q);
            obox_req_o.wdata = data_q;
          end
          CMD_WBIT: begin
            obox_req_o.re    = idx_in_out;
            obox_req_o.raddr = MEM_AW'(idx_q);
          end
          CMD_RBYTE: begin
            hit_d            = idx_in_in;
            ibox_req_o.re    = idx_in_in;
            ibox_req_o.raddr = MEM_AW'(idx_q);
          end
          default: begin
          end
        endcase
      end
      S_RREAD: begin
        obox_req_o.re    = |rcnt_q[REPLY_CW-1:1];
        obox_req_o.raddr = MEM_AW'(rcnt_q - REPLY_CW'(2));
      end
      S_RSEND: begin
        if (free) begin
          emit       = 1'b1;
          emit_value = reply_value;
          emit_last  = reply_last;
          rcnt_d     = rcnt_q + REPLY_CW'(1);
        end
      end
      S_CREAD: stg_re = 1'b1;
      S_CPUT: begin
        ibox_req_o.we    = 1'b1;
        ibox_req_o.waddr = MEM_AW'(ccnt_q);
        ibox_req_o.wdata = stg_rdata_q;
        ccnt_d           = ccnt_q + 5'd1;
      end
      S_RMW: begin
        obox_req_o.we    = 1'b1;
        obox_req_o.waddr = MEM_AW'(idx_q);
        obox_req_o.wdata = rmw_value;
      end
      S_HREAD: begin
        if (free) begin
          emit       = 1'b1;
          emit_kind  = 1'b1;
          emit_value = hit_q ? ibox_rdata_i : 8'd0;
          emit_last  = 1'b1;
        end
      end
      S_FLAG: begin
        if (free) begin
          emit       = 1'b1;
          emit_kind  = 1'b1;
          emit_value = {7'd0, flag_q};
          emit_last  = 1'b1;
          flag_d     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frame_q     <= FR_ONE;
      pcnt_q      <= 5'd0;
      ccnt_q      <= 5'd0;
      rcnt_q      <= '0;
      flag_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      frame_q <= frame_d;
      pcnt_q  <= pcnt_d;
      ccnt_q  <= ccnt_d;
      rcnt_q  <= rcnt_d;
      flag_q  <= flag_d;
      hit_q   <= hit_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_e'(command_i);
      data_q <= data_byte_i;
      idx_q  <= byte_index_i;
      bit_q  <= bit_index_i;
      bval_q <= bit_value_i;
    end
    if (emit) begin
      out_kind_q  <= emit_kind;
      out_value_q <= emit_value;
      out_last_q  <= emit_last;
    end
    if (stg_we) begin
      stg_mem_q[IAW'(pcnt_q)] <= data_q;
    end
    if (stg_re) begin
      stg_rdata_q <= stg_mem_q[IAW'(ccnt_q)];
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/fbsm_chk.sv -----
// Port-level checker for framed_bus_slave_mailbox, bound to the top level.
// Depends on the top-level ports and fbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbsm_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [2:0] command_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       kind_o,
  input wire logic [7:0] value_o,
  input wire logic       last_o
);
  import fbsm_pkg::*;

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  // host replies are single beats
  a_host_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o)
    else $error("host reply beat without last");

  // unknown commands finish without output
  a_unknown_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i > CMD_FLAG) |-> ##2 in_ready_o)
    else $error("unknown command held the block busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) &&
    $stable(kind_o) && $stable(last_o))
    else $error("stalled output beat changed");

endmodule

bind framed_bus_slave_mailbox fbsm_chk u_fbsm_chk (.*);

`default_nettype wire

// ----- tb/sv/framed_bus_slave_mailbox_tb.sv -----
// Self-checking testbench for framed_bus_slave_mailbox: bus frames and host commands
// go in over valid/ready, every reply beat is matched against a built-in predictor.
// Depends on fbsm_pkg and the framed_bus_slave_mailbox RTL.
`timescale 1ns / 1ps

module framed_bus_slave_mailbox_tb;
  import fbsm_pkg::*;

  localparam int unsigned IN_DEPTH  = 16;
  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } reply_t;

  class slave_scoreboard;
    cfg_t        regs;
    frame_e      fstate;
    int unsigned pay_cnt;
    logic [7:0]  staging [IN_DEPTH];
    logic [7:0]  in_box [IN_DEPTH];
    logic [7:0]  out_box [OUT_DEPTH];
    logic        changed;
    reply_t      reply_due [$];
    int unsigned errors;

    function new();
      regs = '0;
      fstate = FR_ONE;
      pay_cnt = 0;
      changed = 1'b0;
      errors = 0;
      foreach (staging[i]) staging[i] = 8'h00;
      foreach (in_box[i]) in_box[i] = 8'h00;
      foreach (out_box[i]) out_box[i] = 8'h00;
    endfunction

    function int unsigned eff_in();
      return (regs.in_size > IN_DEPTH) ? IN_DEPTH : regs.in_size;
    endfunction

    function int unsigned eff_out();
      return (regs.out_size > OUT_DEPTH) ? OUT_DEPTH : regs.out_size;
    endfunction

    function int unsigned pending();
      return reply_due.size();
    endfunction

    function void write_reg(reg_e r, logic [7:0] d);
      case (r)
        REG_UNIT_ID:   regs.unit_id   = d[6:0];
        REG_IN_SIZE:   regs.in_size   = d[4:0];
        REG_OUT_SIZE:  regs.out_size  = d[4:0];
        REG_START_ONE: regs.start_one = d;
        REG_START_TWO: regs.start_two = d;
        REG_REPLY_ONE: regs.reply_one = d;
        REG_REPLY_TWO: regs.reply_two = d;
        REG_WRITE_OP:  regs.write_op  = d[0];
        default: ;
      endcase
    endfunction

    function void owe(logic k, logic [7:0] v, logic l);
      reply_t r;
      r.kind = k;
      r.value = v;
      r.last = l;
      reply_due.push_back(r);
    endfunction

    function void bus_beat(logic [7:0] b);
      int unsigned size;
      int unsigned n;
      size = eff_in();
      n = eff_out();
      case (fstate)
        FR_ONE: if (b == regs.start_one) fstate = FR_TWO;
        FR_TWO: fstate = (b == regs.start_two) ? FR_ADDR : FR_ONE;
        FR_ADDR: begin
          fstate = FR_ONE;
          if (b[7:1] == regs.unit_id) begin
            if (b[0] == regs.write_op) begin
              fstate = FR_PAY;
              pay_cnt = 0;
            end else begin
              owe(1'b0, regs.reply_one, 1'b0);
              owe(1'b0, regs.reply_two, n == 0);
              for (int i = 0; i < n; i++) owe(1'b0, out_box[i], i + 1 == n);
            end
          end
        end
        default: begin
          if (pay_cnt < size) begin
            staging[pay_cnt] = b;
            pay_cnt++;
          end
          if (pay_cnt >= size) begin
            for (int i = 0; i < size; i++) in_box[i] = staging[i];
            changed = 1'b1;
            fstate = FR_ONE;
          end
        end
      endcase
    endfunction

    function void step_slave(logic [2:0] cmd, logic [7:0] data, logic [7:0] idx,
                             logic [2:0] bidx, logic bval);
      case (cmd)
        CMD_BUS:   bus_beat(data);
        CMD_WBYTE: if (idx < eff_out()) out_box[idx] = data;
        CMD_WBIT:  if (idx < eff_out()) out_box[idx][bidx] = bval;
        CMD_RBYTE: owe(1'b1, (idx < eff_in()) ? in_box[idx] : 8'h00, 1'b1);
        CMD_FLAG: begin
          owe(1'b1, {7'b0, changed}, 1'b1);
          changed = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic k, logic [7:0] v, logic l);
      reply_t e;
      if (reply_due.size() == 0) begin
        $display("%0t: unexpected beat kind %0d value %02h last %0d", $time, k, v, l);
        errors++;
        return;
      end
      e = reply_due.pop_front();
      if (k !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
        errors++;
      end
      if (v !== e.value) begin
        $display("%0t: value expected %02h actual %02h", $time, e.value, v);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_cmd = '0;
  logic [7:0] in_data = '0;
  logic [7:0] in_idx = '0;
  logic [2:0] in_bidx = '0;
  logic       in_bval = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_value;
  logic       out_last;

  slave_scoreboard sb;
  int unsigned beats_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_tick = 0;

  framed_bus_slave_mailbox #(
    .IN_MAX (IN_DEPTH),
    .OUT_MAX(OUT_DEPTH)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (in_cmd),
    .data_byte_i (in_data),
    .byte_index_i(in_idx),
    .bit_index_i (in_bidx),
    .bit_value_i (in_bval),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .kind_o      (out_kind),
    .value_o     (out_value),
    .last_o      (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_beat(out_kind, out_value, out_last);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver backpressure: free-flowing, light, periodic and heavy stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (rx_tick % 5 < 2);
      default: out_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  task automatic send_item(input logic [2:0] cmd, input logic [7:0] data,
                           input logic [7:0] idx, input logic [2:0] bidx, input logic bval);
    int unsigned gap;
    if (beats_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      beats_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data <= data;
    in_idx <= idx;
    in_bidx <= bidx;
    in_bval <= bval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.step_slave(cmd, data, idx, bidx, bval);
    beats_left--;
    @(negedge clk);
  endtask

  task automatic bus(input logic [7:0] b);
    send_item(CMD_BUS, b, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    logic [7:0] d;
    reg_e r;
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      r = reg_e'(i);
      case (r)
        REG_UNIT_ID:   d = {1'b0, c.unit_id};
        REG_IN_SIZE:   d = {3'b0, c.in_size};
        REG_OUT_SIZE:  d = {3'b0, c.out_size};
        REG_START_ONE: d = c.start_one;
        REG_START_TWO: d = c.start_two;
        REG_REPLY_ONE: d = c.reply_one;
        REG_REPLY_TWO: d = c.reply_two;
        default:       d = {7'b0, c.write_op};
      endcase
      cfg_we <= 1'b1;
      cfg_idx <= r;
      cfg_data <= d;
      sb.write_reg(r, d);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [4:0] pick_size();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
  endfunction

  function automatic logic [7:0] host_index();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 19));
  endfunction

  task automatic frame(input logic is_write);
    int unsigned n;
    bus(sb.regs.start_one);
    bus(sb.regs.start_two);
    bus({sb.regs.unit_id, is_write ? sb.regs.write_op : ~sb.regs.write_op});
    if (is_write) begin
      n = (sb.eff_in() == 0) ? 1 : sb.eff_in();
      repeat (n) bus(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        frame(1'($urandom_range(0, 1)));
        done += 3;
      end else if (pick < 55) begin
        bus(sb.regs.start_one);
        if ($urandom_range(0, 1)) begin
          bus(8'($urandom_range(0, 255)));
        end else begin
          bus(sb.regs.start_two);
          bus({sb.regs.unit_id ^ 7'($urandom_range(1, 127)), 1'($urandom_range(0, 1))});
        end
        done += 2;
      end else if (pick < 62) begin
        bus(8'($urandom_range(0, 255)));
        done++;
      end else if (pick < 72) begin
        send_item(CMD_WBYTE, 8'($urandom_range(0, 255)), host_index(),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        done++;
      end else if (pick < 80) begin
        send_item(CMD_WBIT, 8'($urandom_range(0, 255)), host_index(),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        done++;
      end else if (pick < 90) begin
        send_item(CMD_RBYTE, 8'($urandom_range(0, 255)), host_index(),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        done++;
      end else if (pick < 96) begin
        send_item(CMD_FLAG, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        done++;
      end else begin
        send_item(3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
      if (done >= count / 2 && done < count / 2 + 3 && $urandom_range(0, 1)) drain();
    end
  endtask

  // leaves a write frame open so the next settings take over mid-frame
  task automatic open_frame();
    if (sb.eff_in() > 1) begin
      bus(sb.regs.start_one);
      bus(sb.regs.start_two);
      bus({sb.regs.unit_id, sb.regs.write_op});
      repeat ($urandom_range(1, sb.eff_in() - 1)) bus(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    cfg_t c;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    c = '{unit_id: 7'h55, in_size: 5'd3, out_size: 5'd2, start_one: 8'hA5,
          start_two: 8'h5A, reply_one: 8'hC3, reply_two: 8'h3C, write_op: 1'b1};
    load_regs(c);
    send_item(CMD_WBYTE, 8'hFF, 8'd0, 3'd0, 1'b0);
    send_item(CMD_WBYTE, 8'h00, 8'd1, 3'd7, 1'b1);
    send_item(CMD_WBYTE, 8'h77, 8'hFF, 3'd0, 1'b0);
    send_item(CMD_WBIT, 8'h00, 8'd1, 3'd7, 1'b1);
    send_item(CMD_WBIT, 8'hFF, 8'd0, 3'd0, 1'b0);
    bus(8'hA5);
    bus(8'h5A);
    bus(8'hAA);
    bus(8'hA5);
    bus(8'h5A);
    bus(8'hAB);
    bus(8'h11);
    bus(8'h22);
    bus(8'h33);
    send_item(CMD_RBYTE, 8'h00, 8'd0, 3'd0, 1'b0);
    send_item(CMD_RBYTE, 8'hFF, 8'd3, 3'd7, 1'b1);
    send_item(CMD_FLAG, 8'h00, 8'd0, 3'd0, 1'b0);
    send_item(CMD_FLAG, 8'h00, 8'd0, 3'd0, 1'b0);
    send_item(CMD_LAST_UNUSED, 8'hFF, 8'hFF, 3'd7, 1'b1);

    // empty write frame and empty read reply
    c = '{unit_id: 7'h00, in_size: 5'd0, out_size: 5'd0, start_one: 8'hFF,
          start_two: 8'h00, reply_one: 8'h00, reply_two: 8'hFF, write_op: 1'b0};
    load_regs(c);
    bus(8'hFF);
    bus(8'h00);
    bus(8'h00);
    bus(8'h42);
    bus(8'hFF);
    bus(8'h00);
    bus(8'h01);
    send_item(CMD_FLAG, 8'h00, 8'd0, 3'd0, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: c = '{unit_id: 7'h7F, in_size: 5'd31, out_size: 5'd31, start_one: 8'hFF,
                 start_two: 8'hFF, reply_one: 8'hFF, reply_two: 8'hFF, write_op: 1'b1};
        2: c = '0;
        default: begin
          c.unit_id = 7'($urandom_range(0, 127));
          c.in_size = (ph == 1) ? 5'd1 : pick_size();
          c.out_size = pick_size();
          c.start_one = 8'($urandom_range(0, 255));
          c.start_two = 8'($urandom_range(0, 255));
          c.reply_one = 8'($urandom_range(0, 255));
          c.reply_two = 8'($urandom_range(0, 255));
          c.write_op = 1'($urandom_range(0, 1));
        end
      endcase
      load_regs(c);
      random_traffic(22);
      if (ph < 6) open_frame();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
